### hw/rtl/spq_pkg.sv
// Package for the sorted priority queue: transaction payload types, operation and
// status codes, and the control group that the queue hands to its cells.
// It depends on nothing else.
package spq_pkg;

	localparam int TAG_W  = 8;
	localparam int PRIO_W = 16;
	localparam int FILL_W = 5;

	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_EXTRACT = 1'b1
	} spq_op_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_EXTRACTED = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} spq_status_t;

	typedef struct packed {
		spq_op_t           op;
		logic [TAG_W-1:0]  tag;
		logic [PRIO_W-1:0] prio;
	} spq_req_t;

	typedef struct packed {
		spq_status_t       status;
		logic [TAG_W-1:0]  out_tag;
		logic [PRIO_W-1:0] out_prio;
		logic [FILL_W-1:0] fill;
	} spq_rsp_t;

	typedef struct packed {
		logic ins;
		logic ext;
	} spq_ctl_t;

endpackage

### hw/rtl/spq_stream_if.sv
// Valid/ready stream interface that carries one payload per transaction.
// The payload type is a parameter; the queue uses the types of spq_pkg.
interface spq_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/spq_cell.sv
// One slot of the sorted queue: holds a tag and a priority and trades them with
// its neighbors on insert and extract. Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
	parameter int PRIO_WIDTH = 16
) (
	input  logic                  clk,
	input  spq_ctl_t              ctl,
	input  logic                  occupied,
	input  logic [TAG_W-1:0]      new_tag,
	input  logic [PRIO_WIDTH-1:0] new_prio,
	input  logic                  left_keep,
	input  logic [TAG_W-1:0]      left_tag,
	input  logic [PRIO_WIDTH-1:0] left_prio,
	input  logic [TAG_W-1:0]      right_tag,
	input  logic [PRIO_WIDTH-1:0] right_prio,
	output logic                  keep,
	output logic [TAG_W-1:0]      tag,
	output logic [PRIO_WIDTH-1:0] prio
);
	logic [TAG_W-1:0]      tag_q;
	logic [PRIO_WIDTH-1:0] prio_q;

	// A held entry stays put when the new one sorts after it.
	assign keep = occupied && (prio_q <= new_prio);
	assign tag  = tag_q;
	assign prio = prio_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && !keep) begin
			if (left_keep) begin
				tag_q  <= new_tag;
				prio_q <= new_prio;
			end else begin
				tag_q  <= left_tag;
				prio_q <= left_prio;
			end
		end else if (ctl.ext) begin
			tag_q  <= right_tag;
			prio_q <= right_prio;
		end
	end
endmodule

### hw/rtl/stable_min_priority_queue.sv
// Sorted priority queue top level: a row of spq_cell slots and the response
// register. Depends on spq_pkg, spq_stream_if and spq_cell.
//
// Usage: requests arrive on req (op, tag, prio) and one response per request
// leaves on rsp (status, out_tag, out_prio, fill). A transaction completes at a
// rising clock edge with valid and ready both high.
// An insert places the entry behind every held entry of equal or lower
// priority, so the lowest priority leaves first and ties leave in arrival
// order. An extract returns the head. Extract on an empty queue answers with
// the empty status; insert on a full queue answers with the full status and
// drops the entry.
// The response is registered and is valid in the cycle after the request is
// taken. Throughput is one request per cycle unless rsp stalls, because every
// slot compares against the new priority in parallel and shifts by one place
// with its neighbor.
// Reset clears the fill count and the response valid flag; slot contents stay
// undefined until written. When the receiver stalls, the response register
// holds its transaction and req.ready drops until rsp is taken; req.ready
// follows rsp.ready combinationally.
module stable_min_priority_queue import spq_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int PRIO_WIDTH = 16
) (
	input logic   clk,
	input logic   arst_n,
	spq_stream_if.sink   req,
	spq_stream_if.source rsp
);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]         held_q;
	logic [CW-1:0]         held_d;
	logic                  rsp_valid_q;
	spq_rsp_t              rsp_q;
	spq_rsp_t              rsp_d;
	spq_ctl_t              ctl;
	logic                  fire;
	logic                  full;
	logic                  empty;
	logic [31:0]           prio_ext;
	logic [PRIO_WIDTH-1:0] new_prio;
	logic [31:0]           head_ext;
	logic [31:0]           fill_ext;

	logic                  keep [CAPACITY];
	logic [TAG_W-1:0]      c_tag [CAPACITY];
	logic [PRIO_WIDTH-1:0] c_prio [CAPACITY];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	assign fire     = req.valid && req.ready;
	assign full     = held_q == CW'(CAPACITY);
	assign empty    = held_q == '0;
	assign prio_ext = 32'(req.data.prio);
	assign new_prio = prio_ext[PRIO_WIDTH-1:0];
	assign ctl.ins  = fire && (req.data.op == OP_INSERT) && !full;
	assign ctl.ext  = fire && (req.data.op == OP_EXTRACT) && !empty;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                  lk;
		logic [TAG_W-1:0]      lt;
		logic [PRIO_WIDTH-1:0] lp;
		logic [TAG_W-1:0]      rt;
		logic [PRIO_WIDTH-1:0] rp;

		if (i == 0) begin : g_first
			assign lk = 1'b1;
			assign lt = req.data.tag;
			assign lp = new_prio;
		end else begin : g_mid
			assign lk = keep[i-1];
			assign lt = c_tag[i-1];
			assign lp = c_prio[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rt = c_tag[i];
			assign rp = c_prio[i];
		end else begin : g_body
			assign rt = c_tag[i+1];
			assign rp = c_prio[i+1];
		end

		spq_cell #(.PRIO_WIDTH(PRIO_WIDTH)) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (CW'(i) < held_q),
			.new_tag    (req.data.tag),
			.new_prio   (new_prio),
			.left_keep  (lk),
			.left_tag   (lt),
			.left_prio  (lp),
			.right_tag  (rt),
			.right_prio (rp),
			.keep       (keep[i]),
			.tag        (c_tag[i]),
			.prio       (c_prio[i])
		);
	end

	assign head_ext = 32'(c_prio[0]);

	always_comb begin
		held_d = held_q;
		if (ctl.ins) begin
			held_d = held_q + CW'(1);
		end else if (ctl.ext) begin
			held_d = held_q - CW'(1);
		end
	end

	assign fill_ext = 32'(held_d);

	always_comb begin
		rsp_d          = '0;
		rsp_d.fill     = fill_ext[FILL_W-1:0];
		if (req.data.op == OP_INSERT) begin
			rsp_d.status = full ? ST_FULL : ST_INSERTED;
		end else if (empty) begin
			rsp_d.status = ST_EMPTY;
		end else begin
			rsp_d.status   = ST_EXTRACTED;
			rsp_d.out_tag  = c_tag[0];
			rsp_d.out_prio = head_ext[PRIO_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			held_q <= held_d;
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(CAPACITY))
		else $error("fill count exceeds capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> held_q == $past(held_q) + CW'(1))
		else $error("insert did not grow the fill count");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.data.op == OP_EXTRACT && empty |=> rsp_q.status == ST_EMPTY)
		else $error("extract on empty queue did not report empty");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		held_q >= CW'(2) |-> c_prio[0] <= c_prio[1])
		else $error("head entry is out of order");
endmodule
